### design/ptrt_pkg.sv
// Package for the pending tune request tracker.
// Event codes, fixed field widths and the queue command struct.
// No dependencies.
package ptrt_pkg;

  localparam int TIME_W = 32;
  localparam int HOLD_W = 16;
  localparam int OWED_W = 8;

  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd1000;
  localparam logic [OWED_W-1:0] OWED_MAX   = 8'hFF;

  typedef enum logic [1:0] {
    MODE_QUERY = 2'd0,
    MODE_SEND  = 2'd1,
    MODE_REPLY = 2'd2,
    MODE_RESET = 2'd3
  } mode_e;

  // clear applies before push; pop is never combined with clear or push
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } q_cmd_t;

endpackage

### design/ptrt_queue.sv
// Circular target queue of the tracker: storage, head pointer, fill count
// and copies of the oldest and newest entries. Depends on ptrt_pkg.
module ptrt_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int FREQ_BITS   = 36
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ptrt_pkg::q_cmd_t                 cmd_i,
  input  logic [FREQ_BITS-1:0]             push_data_i,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] fill_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] fill_next_o,
  output logic [FREQ_BITS-1:0]             oldest_o,
  output logic [FREQ_BITS-1:0]             newest_next_o
);
  import ptrt_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH+1);
  localparam int TAIL_W = PTR_W + 2;

  logic [FREQ_BITS-1:0] mem_q [QUEUE_DEPTH];
  logic [FREQ_BITS-1:0] newest_q, newest_d;
  logic [FREQ_BITS-1:0] oldest_q;
  logic [PTR_W-1:0]     head_q, head_d, head_base, tail_idx;
  logic [CNT_W-1:0]     fill_q, fill_d, fill_base;
  logic [TAIL_W-1:0]    tail_sum, tail_wrap;

  always_comb begin
    head_base = cmd_i.clear ? '0 : head_q;
    fill_base = cmd_i.clear ? '0 : fill_q;
    tail_sum  = TAIL_W'(head_base) + TAIL_W'(fill_base);
    tail_wrap = (tail_sum >= TAIL_W'(QUEUE_DEPTH)) ? tail_sum - TAIL_W'(QUEUE_DEPTH) : tail_sum;
    tail_idx  = tail_wrap[PTR_W-1:0];

    head_d   = head_base;
    fill_d   = fill_base;
    newest_d = newest_q;
    if (cmd_i.push) begin
      fill_d   = fill_base + 1'b1;
      newest_d = push_data_i;
    end else if (cmd_i.pop) begin
      fill_d = fill_q - 1'b1;
      head_d = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  // oldest entry is prefetched: loaded on a push into an empty queue, or
  // read from the next head slot on a pop
  always_ff @(posedge clk_i) begin
    newest_q <= newest_d;
    if (cmd_i.push) begin
      mem_q[tail_idx] <= push_data_i;
      if (fill_base == '0) begin
        oldest_q <= push_data_i;
      end
    end else if (cmd_i.pop) begin
      oldest_q <= mem_q[head_d];
    end
  end

  assign fill_o        = fill_q;
  assign fill_next_o   = fill_d;
  assign oldest_o      = oldest_q;
  assign newest_next_o = newest_d;

endmodule

### design/pending_tune_request_tracker.sv
// Top level of the pending tune request tracker.
// Input register, event logic and result register. Depends on ptrt_pkg, ptrt_queue.
//
// Each transfer on the slave side is one event (mode in tuser: query, send,
// reply, reset) and yields exactly one result transfer on the master side.
// An event is taken into an input register, evaluated by combinational logic
// against the queue, owed-reply counter and last-send time, and lands in a
// result register. One event is accepted every cycle while the master side
// keeps up. hold_time_ms is written through cfg_we_i / cfg_wdata_i and should
// only change while no event is in flight.
module pending_tune_request_tracker #(
  parameter int QUEUE_DEPTH = 16,
  parameter int FREQ_BITS   = 36
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ptrt_pkg::HOLD_W-1:0] cfg_wdata_i,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // freq_hz, now_ms, zero padding
  input  logic [((FREQ_BITS+ptrt_pkg::TIME_W+7)/8)*8-1:0] s_axis_tdata,
  // mode
  input  logic [1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // base_hz, pending_count, owed_count, reply_mismatch, send_refused, zero padding
  output logic [((FREQ_BITS+$clog2(QUEUE_DEPTH+1)+ptrt_pkg::OWED_W+2+7)/8)*8-1:0] m_axis_tdata
);
  import ptrt_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH+1);
  localparam int SUM_W = ((CNT_W > OWED_W) ? CNT_W : OWED_W) + 1;
  localparam int RES_W = FREQ_BITS + CNT_W + OWED_W + 2;
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;

  function automatic logic [OWED_W-1:0] sat_add(input logic [OWED_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    return (s > SUM_W'(OWED_MAX)) ? OWED_MAX : s[OWED_W-1:0];
  endfunction

  logic                 in_vld_q, out_vld_q, advance, fire;
  mode_e                mode_q;
  logic [FREQ_BITS-1:0] freq_q;
  logic [TIME_W-1:0]    now_q, last_q, last_d;
  logic [HOLD_W-1:0]    hold_q;
  logic [OWED_W-1:0]    owed_q, owed_d;
  logic                 within_pre, within_post, mismatch, refused;
  logic [FREQ_BITS-1:0] base;
  q_cmd_t               cmd;
  logic [CNT_W-1:0]     fill, fill_next;
  logic [FREQ_BITS-1:0] oldest, newest_next;
  logic [RES_W-1:0]     res_q;

  assign advance       = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;

  ptrt_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .FREQ_BITS  (FREQ_BITS)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .push_data_i  (freq_q),
    .fill_o       (fill),
    .fill_next_o  (fill_next),
    .oldest_o     (oldest),
    .newest_next_o(newest_next)
  );

  always_comb begin
    within_pre = (now_q - last_q) <= TIME_W'(hold_q);
    cmd      = '0;
    owed_d   = owed_q;
    last_d   = last_q;
    mismatch = 1'b0;
    refused  = 1'b0;
    if (fire) begin
      unique case (mode_q)
        MODE_SEND: begin
          if (!within_pre) begin
            cmd.clear = 1'b1;
            owed_d    = sat_add(owed_q, fill);
          end
          if (within_pre && fill == CNT_W'(QUEUE_DEPTH)) begin
            refused = 1'b1;
          end else begin
            cmd.push = 1'b1;
            last_d   = now_q;
          end
        end
        MODE_REPLY: begin
          if (owed_q != '0) begin
            owed_d = owed_q - 1'b1;
          end else if (fill != '0) begin
            if (oldest != freq_q) begin
              cmd.clear = 1'b1;
              owed_d    = sat_add('0, fill - 1'b1);
              mismatch  = 1'b1;
            end else begin
              cmd.pop = 1'b1;
            end
          end
        end
        MODE_RESET: begin
          cmd.clear = 1'b1;
          owed_d    = '0;
          last_d    = '0;
        end
        default: begin
        end
      endcase
    end
    within_post = (now_q - last_d) <= TIME_W'(hold_q);
    base = (fill_next != '0 && within_post) ? newest_next : freq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      hold_q    <= HOLD_RESET;
      owed_q    <= '0;
      last_q    <= '0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
      if (cfg_we_i) begin
        hold_q <= cfg_wdata_i;
      end
      owed_q <= owed_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      mode_q <= mode_e'(s_axis_tuser);
      freq_q <= s_axis_tdata[FREQ_BITS-1:0];
      now_q  <= s_axis_tdata[FREQ_BITS +: TIME_W];
    end
    if (fire) begin
      res_q <= {refused, mismatch, owed_d, fill_next, base};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_W'(res_q);

endmodule

### design/ptrt_checker.sv
// Port-level checks for the pending tune request tracker, bound to the top.
// Depends on ptrt_pkg and pending_tune_request_tracker.
module ptrt_checker #(
  parameter int QUEUE_DEPTH = 16,
  parameter int FREQ_BITS   = 36
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((FREQ_BITS+$clog2(QUEUE_DEPTH+1)+ptrt_pkg::OWED_W+2+7)/8)*8-1:0] m_axis_tdata
);
  import ptrt_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

  logic [CNT_W-1:0] cnt;
  logic             mis, ref_flag;

  assign cnt      = m_axis_tdata[FREQ_BITS +: CNT_W];
  assign mis      = m_axis_tdata[FREQ_BITS + CNT_W + OWED_W];
  assign ref_flag = m_axis_tdata[FREQ_BITS + CNT_W + OWED_W + 1];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_stall_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt <= CNT_W'(QUEUE_DEPTH))
    else $error("pending count above depth");

  a_mismatch_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && mis |-> cnt == '0 && !ref_flag)
    else $error("mismatch left targets pending");

  a_refused_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ref_flag |-> cnt == CNT_W'(QUEUE_DEPTH))
    else $error("send refused with room in queue");

endmodule

bind pending_tune_request_tracker ptrt_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH),
  .FREQ_BITS  (FREQ_BITS)
) u_ptrt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
